@@ src/cpef_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpef_pkg
// Shared constants, codes and item types of the caliper profile edge finder.
// ----------------------------------------------------------------------------
package cpef_pkg;

    localparam int MAX_LEN    = 512;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 18;
    localparam int SCORE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_LEN    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOICE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [1:0] POL_LIGHT_DARK = 2'd0;
    localparam logic [1:0] POL_DARK_LIGHT = 2'd1;
    localparam logic [1:0] POL_EITHER     = 2'd2;

    localparam logic [1:0] CHOICE_FIRST    = 2'd0;
    localparam logic [1:0] CHOICE_LAST     = 2'd1;
    localparam logic [1:0] CHOICE_STRONGEST = 2'd2;

    localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd2560;
    localparam logic [8:0]         OFFSET_CLAMP    = 9'd192;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } sample_item_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   edge_position;
        logic [SCORE_W-1:0] edge_score;
        logic               overflow;
    } result_item_t;

endpackage

@@ src/cpef_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpef channel interfaces
// Valid/ready channels for profile samples, results and register writes.
// ----------------------------------------------------------------------------
interface cpef_sample_if;
    import cpef_pkg::*;

    logic         valid;
    logic         ready;
    sample_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpef_result_if;
    import cpef_pkg::*;

    logic         valid;
    logic         ready;
    result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpef_cfg_if;
    import cpef_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/caliper_profile_edge_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caliper_profile_edge_finder
// Locates one edge in a smoothed intensity profile with sub-sample refinement.
// ----------------------------------------------------------------------------
// Usage:
//   profile carries one sample item per handshake; last_sample closes the
//   profile. Samples load at one per cycle, while the block is in its load
//   state, into a profile memory with one write and one read port; samples
//   past the memory depth are dropped and reported as overflow. After the
//   closing item the block stops taking samples and scans the memory, one
//   read per cycle, then refines the chosen index with a subtract-compare
//   divider (setup states PREP and NORM, then nine quotient steps) and loads
//   the result register. Profiles shorter than five samples skip the scan
//   and report not found. result holds its item until taken; a stalled
//   receiver blocks only the final hand-off, and loading of the next
//   profile goes on meanwhile.
//   cfg is always ready; write it only while the block is idle.
//   Reset clears the sample count, overflow flag and pending result and sets
//   the registers to polarity either, strongest edge, threshold 2560.
// ----------------------------------------------------------------------------
module caliper_profile_edge_finder (
    input  logic                 clk,
    input  logic                 rst_n,
    cpef_sample_if.sink          profile,
    cpef_result_if.source        result,
    cpef_cfg_if.sink             cfg
);
    import cpef_pkg::*;

    localparam int PF_W  = ADDR_W + POS_W;
    localparam int DIV_W = 27;

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_PREP = 6'b000100,
        ST_NORM = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg;

    logic [1:0]          polarity_reg;
    logic [1:0]          choice_reg;
    logic [SCORE_W-1:0]  threshold_reg;

    logic [SAMPLE_W-1:0] profile_mem [MAX_LEN];
    logic [SAMPLE_W-1:0] mem_q_reg;

    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;
    logic                res_ovf_reg;
    logic [CNT_W-1:0]    n_reg;

    logic [ADDR_W-1:0]   rd_addr_reg;
    logic                rd_issue_reg;
    logic                rv_reg;
    logic [ADDR_W-1:0]   k_reg;
    logic [SAMPLE_W-1:0] p1_reg;
    logic [SAMPLE_W-1:0] p2_reg;
    logic                dv_reg;
    logic signed [16:0]  d_reg;
    logic [ADDR_W-1:0]   dj_reg;
    logic signed [16:0]  dprev_reg;

    logic                have_reg;
    logic                need_c_reg;
    logic [ADDR_W-1:0]   best_reg;
    logic signed [16:0]  best_score_reg;
    logic signed [16:0]  a_reg;
    logic signed [16:0]  b_reg;
    logic signed [16:0]  c_reg;

    logic signed [17:0]  num_reg;
    logic signed [18:0]  den_reg;
    logic                neg_reg;
    logic [25:0]         rem_reg;
    logic [18:0]         dvs_reg;
    logic [3:0]          step_reg;
    logic [8:0]          q_reg;

    logic                out_valid_reg;
    result_item_t        out_data_reg;

    logic                sample_acc;
    logic                store_full;
    logic [CNT_W-1:0]    n_now;
    logic signed [16:0]  score;
    logic signed [16:0]  th_s;
    logic                take;
    logic [17:0]         num_mag;
    logic [18:0]         den_mag;
    logic [DIV_W-1:0]    div_sub;
    logic                div_ge;
    logic [8:0]          mag;
    logic signed [8:0]   sub;
    logic [PF_W-1:0]     pos_full;
    logic                out_free;
    logic                out_load;

    assign profile.ready = (state_reg == ST_LOAD);
    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    assign sample_acc = profile.valid && profile.ready;
    assign store_full = (count_reg >= CNT_W'(MAX_LEN));
    assign n_now      = store_full ? count_reg : count_reg + CNT_W'(1);
    assign out_free   = !out_valid_reg || result.ready;
    assign out_load   = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        th_s = $signed({1'b0, threshold_reg});
        unique case (polarity_reg)
            POL_LIGHT_DARK: score = -d_reg;
            POL_DARK_LIGHT: score = d_reg;
            default:        score = d_reg[16] ? -d_reg : d_reg;
        endcase
        unique case (choice_reg)
            CHOICE_FIRST: take = (score >= th_s) && !have_reg;
            CHOICE_LAST:  take = (score >= th_s);
            default:      take = (score > best_score_reg);
        endcase
    end

    always_comb
    begin
        num_mag  = num_reg[17] ? 18'(-num_reg) : 18'(num_reg);
        den_mag  = den_reg[18] ? 19'(-den_reg) : 19'(den_reg);
        div_sub  = DIV_W'(dvs_reg) << step_reg;
        div_ge   = (DIV_W'(rem_reg) >= div_sub);
        mag      = (q_reg >= OFFSET_CLAMP) ? OFFSET_CLAMP : q_reg;
        sub      = neg_reg ? -$signed(mag) : $signed(mag);
        pos_full = (PF_W'(best_reg) << 8) + PF_W'(sub);
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc && !store_full)
        begin
            profile_mem[count_reg[ADDR_W-1:0]] <= profile.data.sample;
        end
        mem_q_reg <= profile_mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            polarity_reg  <= POL_EITHER;
            choice_reg    <= CHOICE_STRONGEST;
            threshold_reg <= THRESHOLD_RESET;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rd_issue_reg  <= 1'b0;
            rv_reg        <= 1'b0;
            dv_reg        <= 1'b0;
            have_reg      <= 1'b0;
            need_c_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_POLARITY:  polarity_reg  <= cfg.data[1:0];
                    CFG_CHOICE:    choice_reg    <= cfg.data[1:0];
                    CFG_THRESHOLD: threshold_reg <= cfg.data;
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (sample_acc)
                    begin
                        if (profile.data.last_sample)
                        begin
                            res_ovf_reg    <= ovf_reg || store_full;
                            count_reg      <= '0;
                            ovf_reg        <= 1'b0;
                            n_reg          <= n_now;
                            have_reg       <= 1'b0;
                            need_c_reg     <= 1'b0;
                            rd_addr_reg    <= '0;
                            dprev_reg      <= '0;
                            c_reg          <= '0;
                            best_score_reg <= th_s;
                            if (n_now >= CNT_W'(MIN_LEN))
                            begin
                                rd_issue_reg <= 1'b1;
                                state_reg    <= ST_SCAN;
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                        else if (store_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end
                ST_SCAN:
                begin
                    // read stage
                    if (rd_issue_reg)
                    begin
                        rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                        if (CNT_W'(rd_addr_reg) == n_reg - CNT_W'(1))
                        begin
                            rd_issue_reg <= 1'b0;
                        end
                    end
                    rv_reg <= rd_issue_reg;
                    k_reg  <= rd_addr_reg;
                    // difference stage
                    dv_reg <= rv_reg && (k_reg >= ADDR_W'(2));
                    if (rv_reg)
                    begin
                        p1_reg <= mem_q_reg;
                        p2_reg <= p1_reg;
                        d_reg  <= $signed({1'b0, mem_q_reg}) - $signed({1'b0, p2_reg});
                        dj_reg <= k_reg - ADDR_W'(1);
                    end
                    // score and select stage
                    if (dv_reg)
                    begin
                        dprev_reg <= d_reg;
                        if (take)
                        begin
                            have_reg       <= 1'b1;
                            best_reg       <= dj_reg;
                            best_score_reg <= score;
                            a_reg          <= dprev_reg;
                            b_reg          <= d_reg;
                            c_reg          <= '0;
                            need_c_reg     <= 1'b1;
                        end
                        else if (need_c_reg)
                        begin
                            c_reg      <= d_reg;
                            need_c_reg <= 1'b0;
                        end
                        if (CNT_W'(dj_reg) == n_reg - CNT_W'(2))
                        begin
                            state_reg <= ST_PREP;
                        end
                    end
                end
                ST_PREP:
                begin
                    num_reg <= 18'(a_reg) - 18'(c_reg);
                    den_reg <= 19'(a_reg) - (19'(b_reg) <<< 1) + 19'(c_reg);
                    state_reg <= have_reg ? ST_NORM : ST_DONE;
                end
                ST_NORM:
                begin
                    neg_reg   <= num_reg[17] ^ den_reg[18];
                    rem_reg   <= 26'({num_mag[16:0], 8'h00}) + 26'(den_mag[17:0]);
                    dvs_reg   <= {den_mag[17:0], 1'b0};
                    step_reg  <= 4'd8;
                    q_reg     <= '0;
                    state_reg <= (den_reg == '0) ? ST_DONE : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_ge)
                    begin
                        rem_reg <= 26'(DIV_W'(rem_reg) - div_sub);
                    end
                    q_reg    <= {q_reg[7:0], div_ge};
                    step_reg <= step_reg - 4'd1;
                    if (step_reg == 4'd0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_data_reg.found         <= have_reg;
                        out_data_reg.edge_position <= have_reg ? pos_full[POS_W-1:0] : '0;
                        out_data_reg.edge_score    <= have_reg ?
                                                      best_score_reg[SCORE_W-1:0] : '0;
                        out_data_reg.overflow      <= res_ovf_reg;
                        state_reg                  <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
    else $error("sample count beyond store depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.found |->
            out_data_reg.edge_position == '0 && out_data_reg.edge_score == '0)
    else $error("not-found result carries position or score");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP && have_reg |-> best_score_reg >= th_s)
    else $error("chosen edge below contrast threshold");

endmodule

@@ sim/edge_finder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_finder_checker
// Watches the profile, result and register channels of the caliper edge
// finder, predicts the result of each closed profile from its own copy of
// the sample store and registers, and compares each result field by field.
// ----------------------------------------------------------------------------
module edge_finder_checker (
    input  logic          clk,
    input  logic          rst_n,
    cpef_sample_if        profile,
    cpef_result_if        result,
    cpef_cfg_if           cfg,
    output int            failures,
    output int            pending,
    output int            results_seen,
    output int            edges_found,
    output int            overflows_seen
);
    import cpef_pkg::*;

    logic [SAMPLE_W-1:0] stored_profile [MAX_LEN];
    int                  stored_count;
    bit                  dropped;
    logic [1:0]          edge_pol;
    logic [1:0]          edge_pick;
    logic [SCORE_W-1:0]  min_contrast;
    result_item_t        expected_results [$];

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on result %0d: %s got 0x%0h, predicted 0x%0h",
                 $time, results_seen, what, got, want);
        failures++;
    endtask

    function automatic int slope_at(int idx);
        if (idx < 1 || idx + 1 >= stored_count)
            return 0;
        return int'(stored_profile[idx + 1]) - int'(stored_profile[idx - 1]);
    endfunction

    function automatic int polarity_score(int idx);
        int g;
        g = slope_at(idx);
        case (edge_pol)
            POL_LIGHT_DARK: return -g;
            POL_DARK_LIGHT: return g;
            default:        return (g < 0) ? -g : g;
        endcase
    endfunction

    function automatic result_item_t locate_edge();
        result_item_t r;
        int           n;
        int           idx;
        int           s;
        int           best;
        int           best_score;
        int           floor_score;
        bit           have;
        bit           neg;
        longint       a;
        longint       b;
        longint       c;
        longint       den;
        longint       num;
        longint       mag;
        longint       sub;
        n = stored_count;
        best = 0;
        floor_score = int'(min_contrast);
        best_score = floor_score;
        have = 1'b0;
        if (n >= MIN_LEN) begin
            if (edge_pick == CHOICE_FIRST) begin
                for (idx = 1; idx + 1 < n && !have; idx++) begin
                    s = polarity_score(idx);
                    if (s >= floor_score) begin
                        best = idx;
                        best_score = s;
                        have = 1'b1;
                    end
                end
            end
            else if (edge_pick == CHOICE_LAST) begin
                for (idx = n - 2; idx >= 1 && !have; idx--) begin
                    s = polarity_score(idx);
                    if (s >= floor_score) begin
                        best = idx;
                        best_score = s;
                        have = 1'b1;
                    end
                end
            end
            else begin
                for (idx = 1; idx + 1 < n; idx++) begin
                    s = polarity_score(idx);
                    if (s > best_score) begin
                        best = idx;
                        best_score = s;
                        have = 1'b1;
                    end
                end
            end
        end
        r = '0;
        r.overflow = dropped;
        if (have) begin
            a = slope_at(best - 1);
            b = slope_at(best);
            c = slope_at(best + 1);
            den = a - 2 * b + c;
            sub = 0;
            if (den != 0) begin
                num = 128 * (a - c);
                neg = 1'b0;
                if (den < 0) begin
                    den = -den;
                    neg = !neg;
                end
                if (num < 0) begin
                    num = -num;
                    neg = !neg;
                end
                mag = (2 * num + den) / (2 * den);
                if (mag > longint'(OFFSET_CLAMP))
                    mag = longint'(OFFSET_CLAMP);
                sub = neg ? -mag : mag;
            end
            r.found = 1'b1;
            r.edge_position = POS_W'(longint'(best) * 256 + sub);
            r.edge_score = best_score[SCORE_W-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_item_t got;
        result_item_t want;
        if (!rst_n)
        begin
            stored_count = 0;
            dropped = 1'b0;
            edge_pol = POL_EITHER;
            edge_pick = CHOICE_STRONGEST;
            min_contrast = THRESHOLD_RESET;
            expected_results.delete();
            failures = 0;
            pending = 0;
            results_seen = 0;
            edges_found = 0;
            overflows_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_POLARITY:  edge_pol = cfg.data[1:0];
                    CFG_CHOICE:    edge_pick = cfg.data[1:0];
                    CFG_THRESHOLD: min_contrast = cfg.data;
                    default:       ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, found", got.found, 0);
                else
                begin
                    want = expected_results.pop_front();
                    pending--;
                    if (got.found !== want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.edge_position !== want.edge_position)
                        report_mismatch("edge_position", got.edge_position,
                                        want.edge_position);
                    if (got.edge_score !== want.edge_score)
                        report_mismatch("edge_score", got.edge_score, want.edge_score);
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", got.overflow, want.overflow);
                    if (want.found)
                        edges_found++;
                    if (want.overflow)
                        overflows_seen++;
                end
                results_seen++;
            end
            if (profile.valid && profile.ready)
            begin
                if (stored_count < MAX_LEN)
                begin
                    stored_profile[stored_count] = profile.data.sample;
                    stored_count++;
                end
                else
                    dropped = 1'b1;
                if (profile.data.last_sample)
                begin
                    expected_results.insert(expected_results.size(), locate_edge());
                    pending++;
                    stored_count = 0;
                    dropped = 1'b0;
                end
            end
        end
    end

endmodule

@@ sim/caliper_profile_edge_finder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caliper_profile_edge_finder_tb
// Streams directed and random intensity profiles through the edge finder
// under bursty sending and a stalling receiver, sweeps polarity, edge choice
// and contrast threshold between profiles, and reports the checker verdict.
// ----------------------------------------------------------------------------
module caliper_profile_edge_finder_tb;
    import cpef_pkg::*;

    localparam int TARGET_ITEMS       = 1450;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int LONG_PROFILE_AT    = 18;
    localparam int OVERFLOW_PROFILE_AT = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    cpef_sample_if profile_ch ();
    cpef_result_if result_ch ();
    cpef_cfg_if    cfg_ch ();

    int failures;
    int pending;
    int results_seen;
    int edges_found;
    int overflows_seen;
    int samples_sent;
    int profiles_sent;
    int reg_writes;
    int burst_left;
    int cycle_count;

    logic [SAMPLE_W-1:0] shape [$];

    caliper_profile_edge_finder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .profile (profile_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    edge_finder_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .profile        (profile_ch),
        .result         (result_ch),
        .cfg            (cfg_ch),
        .failures       (failures),
        .pending        (pending),
        .results_seen   (results_seen),
        .edges_found    (edges_found),
        .overflows_seen (overflows_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: alternate between always ready, random stalls and long stalls
    initial
    begin
        int stall_left;
        int mode;
        int span;
        result_ch.ready = 1'b0;
        stall_left = 0;
        mode = 0;
        span = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(50, 400);
            end
            span--;
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 2) != 0);
                    default:
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            stall_left = $urandom_range(1, 30);
                            result_ch.ready <= 1'b0;
                        end
                        else
                            result_ch.ready <= 1'b1;
                    end
                endcase
            end
        end
    end

    function automatic int pick_burst();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(20, 120);
        return $urandom_range(0, 8);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return $urandom_range(1, MIN_LEN - 1);
        if (r < 80)
            return $urandom_range(MIN_LEN, 24);
        return $urandom_range(25, 64);
    endfunction

    function automatic logic [SCORE_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SCORE_W'($urandom_range(1, 2000));
            3:       return SCORE_W'($urandom_range(2000, 20000));
            4:       return THRESHOLD_RESET;
            default: return SCORE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // noise, soft steps, random walks, near-flat runs and rail-to-rail toggles
    function automatic void build_shape(int len);
        int style;
        int lo;
        int hi;
        int edge_at;
        int ramp;
        int level;
        int v;
        int k;
        shape.delete();
        style = $urandom_range(0, 4);
        lo = $urandom_range(0, 65535);
        hi = $urandom_range(0, 65535);
        edge_at = $urandom_range(0, len);
        ramp = $urandom_range(1, 4);
        level = $urandom_range(0, 65535);
        for (k = 0; k < len; k++)
        begin
            case (style)
                0: v = $urandom_range(0, 65535);
                1:
                begin
                    if (k < edge_at)
                        v = lo;
                    else if (k >= edge_at + ramp)
                        v = hi;
                    else
                        v = lo + (hi - lo) * (k - edge_at + 1) / (ramp + 1);
                    v += int'($urandom_range(0, 64)) - 32;
                end
                2:
                begin
                    if ($urandom_range(0, 9) == 0)
                        level = $urandom_range(0, 65535);
                    else
                        level += int'($urandom_range(0, 6000)) - 3000;
                    if (level < 0)
                        level = 0;
                    if (level > 65535)
                        level = 65535;
                    v = level;
                end
                3: v = level + int'($urandom_range(0, 8)) - 4;
                default: v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
            endcase
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            shape.insert(shape.size(), v[SAMPLE_W-1:0]);
        end
    endfunction

    task automatic send_sample(logic [SAMPLE_W-1:0] value, logic last);
        int gap;
        profile_ch.valid <= 1'b1;
        profile_ch.data <= '{sample: value, last_sample: last};
        @(posedge clk);
        while (!profile_ch.ready)
            @(posedge clk);
        samples_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            profile_ch.valid <= 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
            burst_left = pick_burst();
        end
    endtask

    task automatic send_profile();
        int k;
        for (k = 0; k < shape.size(); k++)
            send_sample(shape[k], k == shape.size() - 1);
        profiles_sent++;
    endtask

    // drop valid, drain every outstanding result, then let the block settle
    task automatic wait_idle();
        if (profile_ch.valid)
            profile_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int target_len;
        int profile_count;
        logic [1:0] pol_code;
        logic [1:0] pick_code;
        profile_ch.valid = 1'b0;
        profile_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        burst_left = 0;
        samples_sent = 0;
        profiles_sent = 0;
        reg_writes = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: single sample, short profile, rail-to-rail step
        shape = '{16'hFFFF};
        send_profile();
        shape = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
        send_profile();
        shape = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_profile();

        // first edge on a straight derivative run: zero parabola curvature
        wait_idle();
        write_reg(CFG_CHOICE, CHOICE_FIRST);
        write_reg(CFG_THRESHOLD, 16'd1500);
        shape = '{16'd0, 16'd0, 16'd1000, 16'd2000, 16'd4000, 16'd7000, 16'd7000};
        send_profile();

        // rising edge just at threshold beside a steeper one: clamp the offset
        wait_idle();
        write_reg(CFG_POLARITY, POL_DARK_LIGHT);
        write_reg(CFG_THRESHOLD, 16'd1000);
        shape = '{16'd0, 16'd0, 16'd1000, 16'd1300, 16'd1300};
        send_profile();

        // falling edge at zero threshold
        wait_idle();
        write_reg(CFG_POLARITY, POL_LIGHT_DARK);
        write_reg(CFG_THRESHOLD, 16'd0);
        shape = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
        send_profile();

        phase = 0;
        while (samples_sent < TARGET_ITEMS || profiles_sent <= OVERFLOW_PROFILE_AT)
        begin
            wait_idle();
            pol_code = 2'(phase % 4);
            pick_code = (phase < 16) ? 2'((phase / 4) % 4) : 2'($urandom_range(0, 3));
            write_reg(CFG_POLARITY, {14'($urandom()), pol_code});
            write_reg(CFG_CHOICE, {14'($urandom()), pick_code});
            write_reg(CFG_THRESHOLD, pick_threshold());
            if (phase % 5 == 4)
                write_reg(CFG_UNUSED, 16'($urandom()));
            profile_count = $urandom_range(1, 4);
            repeat (profile_count)
            begin
                if (profiles_sent == LONG_PROFILE_AT)
                    target_len = MAX_LEN;
                else if (profiles_sent == OVERFLOW_PROFILE_AT)
                    target_len = $urandom_range(MAX_LEN + 1, MAX_LEN + 20);
                else
                    target_len = pick_length();
                build_shape(target_len);
                send_profile();
            end
            phase++;
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("covered %0d profiles, %0d samples, %0d register writes over %0d phases",
                 profiles_sent, samples_sent, reg_writes, phase);
        $display("checked %0d results: %0d with an edge, %0d with dropped samples",
                 results_seen, edges_found, overflows_seen);
        if (failures == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
